### src/oep_pkg.sv
package oep_pkg;

	localparam int CW          = 32;
	localparam int ZW          = 33;
	localparam int CORDIC_STEPS = 30;
	localparam int DIV_STEPS   = 32;

	localparam logic [1:0] REG_PERT_HARMONIC = 2'd0;
	localparam logic [1:0] REG_PERT_DIVISOR  = 2'd1;

	localparam logic [24:0] DEG_FULL_TURN = 25'd23592960;
	localparam logic [26:0] RECIP45       = 27'd95443717;
	localparam logic [29:0] RAD_TO_PHASE  = 30'd683565276;
	localparam logic signed [CW-1:0] CORDIC_X0 = 32'sd652032874;

	localparam logic [31:0] ATAN_TBL [0:CORDIC_STEPS-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	// floor(k * 8192 / 45): fraction of one 45-step degree slot in phase units
	localparam logic [12:0] FRAC_TBL [0:44] = '{
		13'd0,    13'd182,  13'd364,  13'd546,  13'd728,  13'd910,  13'd1092, 13'd1274,
		13'd1456, 13'd1638, 13'd1820, 13'd2002, 13'd2184, 13'd2366, 13'd2548, 13'd2730,
		13'd2912, 13'd3094, 13'd3276, 13'd3458, 13'd3640, 13'd3822, 13'd4004, 13'd4187,
		13'd4369, 13'd4551, 13'd4733, 13'd4915, 13'd5097, 13'd5279, 13'd5461, 13'd5643,
		13'd5825, 13'd6007, 13'd6189, 13'd6371, 13'd6553, 13'd6735, 13'd6917, 13'd7099,
		13'd7281, 13'd7463, 13'd7645, 13'd7827, 13'd8009
	};

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 flip;
	} cordic_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] num;
		logic [31:0] quo;
		logic [31:0] div;
		logic        ovf;
	} div_t;

endpackage

### src/oep_cordic_cell.sv
module oep_cordic_cell #(
	parameter int unsigned Step = 0
) (
	input  logic            clk,
	input  logic            en,
	input  oep_pkg::cordic_t d,
	output oep_pkg::cordic_t q
);
	import oep_pkg::*;

	localparam logic signed [ZW-1:0] Atan = $signed({1'b0, ATAN_TBL[Step]});

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	cordic_t              nxt;

	always_comb begin
		dx = d.y >>> Step;
		dy = d.x >>> Step;
		nxt = d;
		if (!d.z[ZW-1]) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - Atan;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + Atan;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

### src/oep_div_cell.sv
module oep_div_cell (
	input  logic          clk,
	input  logic          en,
	input  oep_pkg::div_t d,
	output oep_pkg::div_t q
);
	import oep_pkg::*;

	logic [32:0] trial;
	logic [33:0] diff;
	logic        ge;
	div_t        nxt;

	// one quotient bit per cell, next dividend bit shifted in from num
	always_comb begin
		trial = {d.rem, d.num[31]};
		diff = {1'b0, trial} - {2'b00, d.div};
		ge = ~diff[33];
		nxt = d;
		nxt.rem = ge ? diff[31:0] : trial[31:0];
		nxt.num = {d.num[30:0], 1'b0};
		nxt.quo = {d.quo[30:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

### src/orbit_ellipse_point.sv
// Star point on a tilted ellipse. One item is taken per cycle while in_ready is
// high. The pipeline holds the 30-cell CORDIC chains (three in parallel, for the
// orbit angle, the tilt and the perturbation harmonic) and the 32-cell divider
// chain that forms the perturbation amplitude. An output register with a skid
// stage lets the pipeline keep moving while the consumer stalls until one more
// result has arrived; after that in_ready drops until the skid stage drains.
// pert_harmonic and pert_divisor are written through the cfg port; the user must
// write them only while no item is in flight, which the block itself does not enforce.
module orbit_ellipse_point (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [24:0]        position_deg,
	input  logic signed [23:0] tilt_rad,
	input  logic [31:0]        semi_major,
	input  logic [31:0]        semi_minor,
	input  logic signed [31:0] centre_x,
	input  logic signed [31:0] centre_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [34:0] point_x,
	output logic signed [34:0] point_y
);
	import oep_pkg::*;

	localparam int LAST      = 43;
	localparam int SIDE_LAST = 41;

	typedef struct packed {
		logic [31:0]        a;
		logic [31:0]        b;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
	} side_t;

	function automatic cordic_t fold(input logic [31:0] ph);
		logic signed [31:0] z;
		logic [31:0]        p;
		cordic_t            c;
		z = signed'(ph);
		p = ph - 32'h8000_0000;
		c.x = CORDIC_X0;
		c.y = '0;
		c.z = ZW'(z);
		c.flip = 1'b0;
		if (z > 32'sd1073741824 || z < -32'sd1073741824) begin
			c.z = ZW'(signed'(p));
			c.flip = 1'b1;
		end
		return c;
	endfunction

	function automatic logic signed [33:0] rnd_q30(input logic signed [65:0] p);
		logic signed [65:0] t;
		t = p + 66'sd536870912;
		return t[63:30];
	endfunction

	function automatic logic [34:0] sat_out(input logic signed [36:0] v);
		logic [34:0] r;
		r = v[34:0];
		if (v > 37'sd17179869183) begin
			r = 35'h3_FFFF_FFFF;
		end else if (v < -37'sd17179869184) begin
			r = 35'h4_0000_0000;
		end
		return r;
	endfunction

	logic [7:0]  pert_harmonic_q;
	logic [31:0] pert_divisor_q;
	logic        en;
	logic [LAST:1] vld_q;
	side_t       side_q [1:SIDE_LAST];

	// front: angle reduction and phase forming
	logic [24:0] r_s1, r_s2;
	logic [23:0] mag_s1;
	logic        neg_s1, neg_s2;
	logic [51:0] qm_s2;
	logic [53:0] mp_s2;
	logic [18:0] q_s3;
	logic [5:0]  rem_s3;
	logic [31:0] phb_s3, phb_s4, phb_s5;
	logic [31:0] pha_s4, pha_s5, php_s5;

	logic [19:0] q0_c;
	logic [24:0] prod45_c;
	logic [6:0]  rem0_c;
	logic        fix_c;
	logic [53:0] mr_c;
	logic [31:0] m_c;
	logic [40:0] php_c;

	cordic_t cra [0:CORDIC_STEPS];
	cordic_t crb [0:CORDIC_STEPS];
	cordic_t crp [0:CORDIC_STEPS];
	div_t    dv  [0:DIV_STEPS];

	// back: products and sums
	logic signed [CW-1:0] sa_s37, ca_s37, sb_s37, cb_s37, sp_s37, cp_s37;
	logic signed [CW-1:0] sb_s38, cb_s38, sb_s39, cb_s39;
	logic signed [64:0]   pac_s38, pbs_s38, pqs_s38, pqc_s38;
	logic signed [33:0]   acos_s39, bsin_s39, pqs_s39, pqc_s39;
	logic signed [65:0]   t1_s40, t2_s40, t3_s40, t4_s40;
	logic signed [33:0]   pqs_s40, pqc_s40;
	logic signed [33:0]   t1_s41, t2_s41, t3_s41, t4_s41, pqs_s41, pqc_s41;
	logic signed [35:0]   sx_s42, sy_s42;
	logic signed [33:0]   pqx_s42, pqy_s42;
	logic signed [36:0]   px_s43, py_s43;
	logic [31:0]          qsat_c;
	logic                 pert_on;

	logic        out_valid_q, skid_valid_q, take;
	logic [34:0] out_x_q, out_y_q, skid_x_q, skid_y_q;

	assign en = ~skid_valid_q;
	assign in_ready = en;
	assign pert_on = (pert_harmonic_q != 8'd0) && (pert_divisor_q != 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pert_harmonic_q <= '0;
			pert_divisor_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PERT_HARMONIC: pert_harmonic_q <= cfg_data[7:0];
				REG_PERT_DIVISOR:  pert_divisor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		q0_c = qm_s2[51:32];
		prod45_c = {5'b0, q0_c} * 25'd45;
		rem0_c = 7'(r_s2 - prod45_c);
		fix_c = rem0_c >= 7'd45;
		mr_c = mp_s2 + 54'd32768;
		m_c = mr_c[47:16];
		php_c = pha_s4 * {pert_harmonic_q, 1'b0};
		qsat_c = dv[DIV_STEPS].ovf ? 32'hFFFF_FFFF : dv[DIV_STEPS].quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAST-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= (position_deg >= DEG_FULL_TURN) ? position_deg - DEG_FULL_TURN : position_deg;
			mag_s1 <= tilt_rad[23] ? 24'(-tilt_rad) : 24'(tilt_rad);
			neg_s1 <= tilt_rad[23];
			side_q[1] <= '{a: semi_major, b: semi_minor, cx: centre_x, cy: centre_y};
			for (int k = 2; k <= SIDE_LAST; k++) begin
				side_q[k] <= side_q[k-1];
			end

			r_s2 <= r_s1;
			neg_s2 <= neg_s1;
			qm_s2 <= r_s1 * RECIP45;
			mp_s2 <= mag_s1 * RAD_TO_PHASE;

			// reciprocal estimate can be one low
			q_s3 <= fix_c ? 19'(q0_c + 20'd1) : q0_c[18:0];
			rem_s3 <= fix_c ? 6'(rem0_c - 7'd45) : rem0_c[5:0];
			phb_s3 <= neg_s2 ? m_c : 32'd0 - m_c;

			pha_s4 <= {q_s3, 13'b0} + {19'b0, FRAC_TBL[rem_s3]};
			phb_s4 <= phb_s3;

			pha_s5 <= pha_s4;
			phb_s5 <= phb_s4;
			php_s5 <= php_c[31:0];
			dv[0] <= '{rem: {16'b0, side_q[4].a[31:16]}, num: {side_q[4].a[15:0], 16'b0},
				quo: '0, div: pert_divisor_q,
				ovf: ({16'b0, side_q[4].a} >= {pert_divisor_q, 16'b0})};

			cra[0] <= fold(pha_s5);
			crb[0] <= fold(phb_s5);
			crp[0] <= fold(php_s5);

			// undo the half-turn fold
			sa_s37 <= cra[CORDIC_STEPS].flip ? -cra[CORDIC_STEPS].y : cra[CORDIC_STEPS].y;
			ca_s37 <= cra[CORDIC_STEPS].flip ? -cra[CORDIC_STEPS].x : cra[CORDIC_STEPS].x;
			sb_s37 <= crb[CORDIC_STEPS].flip ? -crb[CORDIC_STEPS].y : crb[CORDIC_STEPS].y;
			cb_s37 <= crb[CORDIC_STEPS].flip ? -crb[CORDIC_STEPS].x : crb[CORDIC_STEPS].x;
			sp_s37 <= crp[CORDIC_STEPS].flip ? -crp[CORDIC_STEPS].y : crp[CORDIC_STEPS].y;
			cp_s37 <= crp[CORDIC_STEPS].flip ? -crp[CORDIC_STEPS].x : crp[CORDIC_STEPS].x;

			pac_s38 <= $signed({1'b0, side_q[37].a}) * ca_s37;
			pbs_s38 <= $signed({1'b0, side_q[37].b}) * sa_s37;
			pqs_s38 <= $signed({1'b0, qsat_c}) * sp_s37;
			pqc_s38 <= $signed({1'b0, qsat_c}) * cp_s37;
			sb_s38 <= sb_s37;
			cb_s38 <= cb_s37;

			acos_s39 <= rnd_q30(pac_s38);
			bsin_s39 <= rnd_q30(pbs_s38);
			pqs_s39 <= rnd_q30(pqs_s38);
			pqc_s39 <= rnd_q30(pqc_s38);
			sb_s39 <= sb_s38;
			cb_s39 <= cb_s38;

			t1_s40 <= acos_s39 * cb_s39;
			t2_s40 <= bsin_s39 * sb_s39;
			t3_s40 <= acos_s39 * sb_s39;
			t4_s40 <= bsin_s39 * cb_s39;
			pqs_s40 <= pqs_s39;
			pqc_s40 <= pqc_s39;

			t1_s41 <= rnd_q30(t1_s40);
			t2_s41 <= rnd_q30(t2_s40);
			t3_s41 <= rnd_q30(t3_s40);
			t4_s41 <= rnd_q30(t4_s40);
			pqs_s41 <= pqs_s40;
			pqc_s41 <= pqc_s40;

			sx_s42 <= 36'(side_q[SIDE_LAST].cx) + 36'(t1_s41) - 36'(t2_s41);
			sy_s42 <= 36'(side_q[SIDE_LAST].cy) + 36'(t3_s41) + 36'(t4_s41);
			pqx_s42 <= pert_on ? pqs_s41 : '0;
			pqy_s42 <= pert_on ? pqc_s41 : '0;

			px_s43 <= 37'(sx_s42) + 37'(pqx_s42);
			py_s43 <= 37'(sy_s42) + 37'(pqy_s42);
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		oep_cordic_cell #(.Step(i)) u_cell_a (.clk, .en, .d(cra[i]), .q(cra[i+1]));
		oep_cordic_cell #(.Step(i)) u_cell_b (.clk, .en, .d(crb[i]), .q(crb[i+1]));
		oep_cordic_cell #(.Step(i)) u_cell_p (.clk, .en, .d(crp[i]), .q(crp[i+1]));
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		oep_div_cell u_cell (.clk, .en, .d(dv[k]), .q(dv[k+1]));
	end

	// output register with one skid entry
	assign take = out_ready | ~out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (take) begin
			out_valid_q <= vld_q[LAST];
		end else if (vld_q[LAST]) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_x_q <= skid_x_q;
				out_y_q <= skid_y_q;
			end
		end else if (take) begin
			out_x_q <= sat_out(px_s43);
			out_y_q <= sat_out(py_s43);
		end else begin
			skid_x_q <= sat_out(px_s43);
			skid_y_q <= sat_out(py_s43);
		end
	end

	assign out_valid = out_valid_q;
	assign point_x = signed'(out_x_q);
	assign point_y = signed'(out_y_q);

endmodule

### src/oep_checker.sv
module oep_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [34:0] point_x,
	input logic signed [34:0] point_y
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(point_x) && $stable(point_y))
		else $error("result changed while stalled");

	// input side only blocks when a result is waiting
	a_ready_low_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input blocked with no result waiting");

	a_ready_low_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input blocked without a stalled transfer");

endmodule

bind orbit_ellipse_point oep_checker u_oep_checker (.*);
